// ===== src/multichannel_lamp_dimmer_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Lamp dimmer sequencer assertion macros
// Shared property shorthands, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_LAMP_DIMMER_SEQUENCER_UNIT_DEFINES_SVH
`define MULTICHANNEL_LAMP_DIMMER_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define MLDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mlds_pkg.sv =====
// ----------------------------------------------------------------------------
// mlds_pkg
// Types, widths and defaults shared by the lamp dimmer sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlds_pkg;

  localparam int NUM_LAMPS_DEF     = 64;
  localparam int RASTER_STEPS_DEF  = 256;
  localparam int MAX_INTERVALS_DEF = 256;

  localparam int OPC_W      = 2;
  localparam int LAMP_IDX_W = 6;
  localparam int BRIGHT_W   = 8;
  localparam int IV_W       = 8;
  localparam int GAP_W      = 8;
  localparam int OUT_W      = 64;
  localparam int TSTEP_W    = 8;
  localparam int RES_W      = 9;
  localparam int GAP_SPAN   = 256;

  localparam logic [RES_W-1:0] RES_RESET = 9'd16;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_LAMP = 2'd1,
    OP_SET_GAP  = 2'd2,
    OP_REBUILD  = 2'd3
  } mlds_op_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } mlds_alu_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RB_CLEAR,
    S_RB_READ,
    S_RB_ADD,
    S_RB_MOD,
    S_T_MARK,
    S_T_NEXT,
    S_T_APPLY
  } mlds_state_t;

  typedef struct packed {
    logic                  live_we;
    logic [LAMP_IDX_W-1:0] live_idx;
    logic [BRIGHT_W-1:0]   live_val;
    logic                  snap_copy;
  } mlds_lamp_ctrl_t;

endpackage

// ===== src/mlds_alu.sv =====
// ----------------------------------------------------------------------------
// mlds_alu
// Shared add/subtract unit; ovf is carry out on add, borrow on subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlds_alu #(
  parameter int W = 9
) (
  input  logic                  [W-1:0] a,
  input  logic                  [W-1:0] b,
  input  mlds_pkg::mlds_alu_op_t        op,
  output logic                  [W-1:0] res,
  output logic                          ovf
);
  import mlds_pkg::*;

  logic [W:0] ext;

  always_comb begin
    unique case (op)
      ALU_ADD: ext = {1'b0, a} + {1'b0, b};
      ALU_SUB: ext = {1'b0, a} - {1'b0, b};
      default: ext = '0;
    endcase
  end

  assign res = ext[W-1:0];
  assign ovf = ext[W];

endmodule

// ===== src/mlds_lamp_bank.sv =====
// ----------------------------------------------------------------------------
// mlds_lamp_bank
// Per-lamp live and snapshot brightness lanes with target match compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlds_lamp_bank #(
  parameter int NUM_LAMPS = mlds_pkg::NUM_LAMPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlds_pkg::mlds_lamp_ctrl_t            ctrl,
  input  logic [mlds_pkg::BRIGHT_W-1:0]        tgt,
  output logic [NUM_LAMPS-1:0]                 match
);
  import mlds_pkg::*;

  localparam int LAMP_W = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;

  logic [BRIGHT_W-1:0] live [NUM_LAMPS];
  logic [BRIGHT_W-1:0] snap [NUM_LAMPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NUM_LAMPS; n++) begin
        live[n] <= '0;
        snap[n] <= '0;
      end
    end else begin
      if (ctrl.live_we) begin
        live[ctrl.live_idx[LAMP_W-1:0]] <= ctrl.live_val;
      end
      if (ctrl.snap_copy) begin
        snap <= live;
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NUM_LAMPS; n++) begin
      match[n] = (snap[n] != '0) && (snap[n] == tgt);
    end
  end

endmodule

// ===== src/multichannel_lamp_dimmer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_lamp_dimmer_sequencer_unit
// Multi-lamp phase-angle dimmer: raster step table, gap table and lamp latch.
// ----------------------------------------------------------------------------
// Sequence: after its transfer a tick runs the table read, interval compare,
// next-step read and latch update before the next transfer can be taken; the
// result is registered at the latch update, which waits while the previous
// result waits at the output. Lamp and gap writes are taken from S_IDLE. A
// rebuild clears the step table, then reads, adds and reduces per interval,
// with an extra reduce step for each wrap of the running sum past RASTER_STEPS,
// all on the one shared adder. After reset the step and gap tables are cleared
// by a pass over max(RASTER_STEPS, MAX_INTERVALS) entries with in_ready low;
// cfg writes are always taken.
`timescale 1ns / 1ps
`include "multichannel_lamp_dimmer_sequencer_unit_defines.svh"

module multichannel_lamp_dimmer_sequencer_unit #(
  parameter int NUM_LAMPS     = mlds_pkg::NUM_LAMPS_DEF,
  parameter int RASTER_STEPS  = mlds_pkg::RASTER_STEPS_DEF,
  parameter int MAX_INTERVALS = mlds_pkg::MAX_INTERVALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlds_pkg::RES_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mlds_pkg::OPC_W-1:0]        opcode,
  input  logic [mlds_pkg::LAMP_IDX_W-1:0]   lamp_index,
  input  logic [mlds_pkg::BRIGHT_W-1:0]     brightness,
  input  logic [mlds_pkg::IV_W-1:0]         interval_index,
  input  logic [mlds_pkg::GAP_W-1:0]        gap_steps,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mlds_pkg::OUT_W-1:0]        lamp_outputs,
  output logic                              changed,
  output logic [mlds_pkg::TSTEP_W-1:0]      tick_step
);
  import mlds_pkg::*;

  localparam int STEP_W     = $clog2(RASTER_STEPS);
  localparam int ALU_W      = $clog2(RASTER_STEPS + GAP_SPAN);
  localparam int MI_W       = $clog2(MAX_INTERVALS);
  localparam int INIT_DEPTH = (RASTER_STEPS > MAX_INTERVALS) ? RASTER_STEPS : MAX_INTERVALS;
  localparam int CLR_W      = $clog2(INIT_DEPTH);
  localparam int ENT_W      = IV_W + 1;

  mlds_state_t state, state_next;
  mlds_op_t    op;

  logic [RES_W-1:0]     resolution;
  logic [RES_W-1:0]     r_eff;
  logic [IV_W-1:0]      last;
  logic [CLR_W-1:0]     clr_idx;
  logic [STEP_W-1:0]    sum;
  logic [ALU_W-1:0]     sum_acc;
  logic [RES_W-1:0]     iv_cnt;
  logic [RES_W-1:0]     iv_inc;
  logic [STEP_W-1:0]    step_counter;
  logic [STEP_W-1:0]    step_next;
  logic [STEP_W-1:0]    nxt_step;
  logic [IV_W-1:0]      tgt;
  logic                 hit;
  logic                 clr_all;
  logic [NUM_LAMPS-1:0] latch;
  logic [NUM_LAMPS-1:0] latch_upd;
  logic [NUM_LAMPS-1:0] match;

  logic in_fire, out_free, lamp_sel, gap_sel, clr_end_init, clr_end_rb, iv_done, mark_hit;

  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  mlds_alu_op_t     alu_op;
  logic             alu_ovf;

  logic [ENT_W-1:0]  step_mem [RASTER_STEPS];
  logic [GAP_W-1:0]  gap_mem  [MAX_INTERVALS];
  logic              step_we, gap_we;
  logic [STEP_W-1:0] step_waddr, step_raddr;
  logic [ENT_W-1:0]  step_wdata, step_q;
  logic [MI_W-1:0]   gap_waddr, gap_raddr;
  logic [GAP_W-1:0]  gap_wdata, gap_q;

  mlds_lamp_ctrl_t lamp_ctrl;

  mlds_alu #(.W(ALU_W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res),
    .ovf (alu_ovf)
  );

  mlds_lamp_bank #(.NUM_LAMPS(NUM_LAMPS)) u_lamp_bank (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lamp_ctrl),
    .tgt   (tgt),
    .match (match)
  );

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign op           = mlds_op_t'(opcode);
  assign out_free     = !out_valid || out_ready;
  assign r_eff        = (resolution > RES_W'(MAX_INTERVALS)) ? RES_W'(MAX_INTERVALS) : resolution;
  assign last         = IV_W'(r_eff - RES_W'(1));
  assign lamp_sel     = {1'b0, lamp_index} < (LAMP_IDX_W + 1)'(NUM_LAMPS);
  assign gap_sel      = {1'b0, interval_index} < (IV_W + 1)'(MAX_INTERVALS);
  assign clr_end_init = (clr_idx == CLR_W'(INIT_DEPTH - 1));
  assign clr_end_rb   = (clr_idx == CLR_W'(RASTER_STEPS - 1));
  assign iv_inc       = iv_cnt + RES_W'(1);
  assign iv_done      = (iv_inc == r_eff);
  assign nxt_step     = (alu_res == ALU_W'(RASTER_STEPS)) ? '0 : alu_res[STEP_W-1:0];
  assign mark_hit     = step_q[IV_W] && (r_eff != '0) && !alu_ovf;
  assign latch_upd    = clr_all ? '0 : (hit ? (latch | match) : latch);

  // table memories
  always_ff @(posedge clk) begin
    if (step_we) begin
      step_mem[step_waddr] <= step_wdata;
    end
    step_q <= step_mem[step_raddr];
  end

  always_ff @(posedge clk) begin
    if (gap_we) begin
      gap_mem[gap_waddr] <= gap_wdata;
    end
    gap_q <= gap_mem[gap_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_end_init) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_TICK:    state_next = S_T_MARK;
            OP_REBUILD: state_next = S_RB_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_RB_CLEAR: begin
        if (clr_end_rb) state_next = (r_eff == '0) ? S_IDLE : S_RB_READ;
      end
      S_RB_READ: state_next = S_RB_ADD;
      S_RB_ADD:  state_next = S_RB_MOD;
      S_RB_MOD: begin
        if (alu_ovf) state_next = iv_done ? S_IDLE : S_RB_READ;
      end
      S_T_MARK:  state_next = S_T_NEXT;
      S_T_NEXT:  state_next = S_T_APPLY;
      S_T_APPLY: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // datapath controls
  always_comb begin
    alu_a      = '0;
    alu_b      = '0;
    alu_op     = ALU_ADD;
    step_we    = 1'b0;
    step_waddr = clr_idx[STEP_W-1:0];
    step_wdata = '0;
    step_raddr = step_counter;
    gap_we     = 1'b0;
    gap_waddr  = interval_index[MI_W-1:0];
    gap_wdata  = gap_steps;
    gap_raddr  = iv_cnt[MI_W-1:0];
    lamp_ctrl  = '{live_we: 1'b0, live_idx: lamp_index, live_val: brightness, snap_copy: 1'b0};
    unique case (state)
      S_INIT: begin
        step_we   = {1'b0, clr_idx} < (CLR_W + 1)'(RASTER_STEPS);
        gap_we    = {1'b0, clr_idx} < (CLR_W + 1)'(MAX_INTERVALS);
        gap_waddr = clr_idx[MI_W-1:0];
        gap_wdata = '0;
      end
      S_IDLE: begin
        gap_we              = in_fire && (op == OP_SET_GAP) && gap_sel;
        lamp_ctrl.live_we   = in_fire && (op == OP_SET_LAMP) && lamp_sel;
        lamp_ctrl.snap_copy = in_fire && (op == OP_REBUILD);
      end
      S_RB_CLEAR: begin
        step_we = 1'b1;
      end
      S_RB_READ: begin
      end
      S_RB_ADD: begin
        alu_a = ALU_W'(sum);
        alu_b = ALU_W'(gap_q);
      end
      S_RB_MOD: begin
        alu_a      = sum_acc;
        alu_b      = ALU_W'(RASTER_STEPS);
        alu_op     = ALU_SUB;
        step_we    = alu_ovf;
        step_waddr = sum_acc[STEP_W-1:0];
        step_wdata = {1'b1, iv_cnt[IV_W-1:0]};
      end
      S_T_MARK: begin
        alu_a  = ALU_W'(last);
        alu_b  = ALU_W'(step_q[IV_W-1:0]);
        alu_op = ALU_SUB;
      end
      S_T_NEXT: begin
        alu_a      = ALU_W'(step_counter);
        alu_b      = ALU_W'(1);
        step_raddr = nxt_step;
      end
      S_T_APPLY: begin
        step_raddr          = step_next;
        lamp_ctrl.snap_copy = out_free && step_q[IV_W] && (step_q[IV_W-1:0] == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      resolution   <= RES_RESET;
      clr_idx      <= '0;
      sum          <= '0;
      iv_cnt       <= '0;
      step_counter <= '0;
      hit          <= 1'b0;
      clr_all      <= 1'b0;
      latch        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        resolution <= cfg_data;
      end
      if ((state == S_T_APPLY) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_idx <= clr_idx + CLR_W'(1);
        end
        S_IDLE: begin
          if (in_fire && (op == OP_REBUILD)) begin
            clr_idx      <= '0;
            sum          <= '0;
            iv_cnt       <= '0;
            step_counter <= '0;
            latch        <= '0;
          end
        end
        S_RB_CLEAR: begin
          clr_idx <= clr_idx + CLR_W'(1);
        end
        S_RB_READ: begin
        end
        S_RB_ADD: begin
          sum_acc <= alu_res;
        end
        S_RB_MOD: begin
          if (!alu_ovf) begin
            sum_acc <= alu_res;
          end else begin
            sum    <= sum_acc[STEP_W-1:0];
            iv_cnt <= iv_inc;
          end
        end
        S_T_MARK: begin
          tgt     <= alu_res[IV_W-1:0];
          hit     <= mark_hit;
          clr_all <= mark_hit && (alu_res[IV_W-1:0] == '0);
        end
        S_T_NEXT: begin
          step_next <= nxt_step;
        end
        S_T_APPLY: begin
          if (out_free) begin
            latch        <= latch_upd;
            lamp_outputs <= OUT_W'(latch_upd);
            changed      <= (latch_upd != latch);
            tick_step    <= TSTEP_W'(step_counter);
            step_counter <= step_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `MLDS_ASSERT_NXT(a_apply_emits, (state == S_T_APPLY) && out_free, out_valid && (state == S_IDLE), "tick did not produce a result")
  `MLDS_ASSERT_NXT(a_out_matches_latch, (state == S_T_APPLY) && out_free, lamp_outputs == OUT_W'(latch), "output disagrees with latch")
  `MLDS_ASSERT_IMP(a_step_in_range, 1'b1, {1'b0, step_counter} < (STEP_W + 1)'(RASTER_STEPS), "step counter out of raster")

endmodule
